// File: rtl/core/twcw_pkg.sv
`default_nettype none

package twcw_pkg;

    // Screen geometry and cell store size.
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 30;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int CELL_AW     = $clog2(CELL_COUNT);

    // Character and attribute constants.
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] DEFAULT_ATTR = 8'h0F;

    // Configuration register width and indexes.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 8;

    typedef enum logic [CFG_IW-1:0] {
        REG_WIN_LEFT   = 3'd0,
        REG_WIN_TOP    = 3'd1,
        REG_WIN_WIDTH  = 3'd2,
        REG_WIN_HEIGHT = 3'd3,
        REG_SCROLL_EN  = 3'd4,
        REG_TEXT_ATTR  = 3'd5
    } t_cfg_reg;

    // Command codes of an input word.
    typedef enum logic [1:0] {
        CMD_PUT  = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // Input and output words.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
    } t_in_word;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } t_out_word;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CLEAR   = 4'd1,
        OP_LOAD    = 4'd2,
        OP_WRAP    = 4'd3,
        OP_MOVE    = 4'd4,
        OP_READ    = 4'd5,
        OP_CAPTURE = 4'd6,
        OP_SCR_RD  = 4'd7,
        OP_SCR_WR  = 4'd8,
        OP_FILL    = 4'd9,
        OP_PUT     = 4'd10,
        OP_EMIT    = 4'd11
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic newline;
        logic wrap_scroll;
        logic single_row;
        logic col_last;
        logic row_last;
        logic clear_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/core/twcw_ctrl.sv
`default_nettype none

module twcw_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  twcw_pkg::t_dp_status i_status,
    output twcw_pkg::t_dp_ctrl   o_ctrl
);
    import twcw_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_DECODE  = 9'b000000100,
        S_RD_WAIT = 9'b000001000,
        S_SCR_RD  = 9'b000010000,
        S_SCR_WR  = 9'b000100000,
        S_FILL    = 9'b001000000,
        S_PUT     = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass over the cell store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and the datapath operation for this cycle.
    always_comb begin
        n_state    = r_state;
        o_ctrl.op  = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctrl.op = OP_CLEAR;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.op = OP_LOAD;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.cmd)
                    CMD_PUT: begin
                        o_ctrl.op = OP_WRAP;
                        if (i_status.wrap_scroll) begin
                            n_state = i_status.single_row ? S_FILL : S_SCR_RD;
                        end else begin
                            n_state = i_status.newline ? S_DONE : S_PUT;
                        end
                    end
                    CMD_MOVE: begin
                        o_ctrl.op = OP_MOVE;
                        n_state   = S_DONE;
                    end
                    CMD_READ: begin
                        o_ctrl.op = OP_READ;
                        n_state   = S_RD_WAIT;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD_WAIT: begin
                o_ctrl.op = OP_CAPTURE;
                n_state   = S_DONE;
            end
            S_SCR_RD: begin
                o_ctrl.op = OP_SCR_RD;
                n_state   = S_SCR_WR;
            end
            S_SCR_WR: begin
                o_ctrl.op = OP_SCR_WR;
                if (i_status.col_last && i_status.row_last) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_SCR_RD;
                end
            end
            S_FILL: begin
                o_ctrl.op = OP_FILL;
                if (i_status.col_last) begin
                    n_state = i_status.newline ? S_DONE : S_PUT;
                end
            end
            S_PUT: begin
                o_ctrl.op = OP_PUT;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_ctrl.op = OP_EMIT;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/twcw_dp.sv
`default_nettype none

module twcw_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  twcw_pkg::t_dp_ctrl           i_ctrl,
    output twcw_pkg::t_dp_status         o_status,
    input  twcw_pkg::t_in_word           i_in_item,
    input  wire                          i_cfg_we,
    input  wire [twcw_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  wire [twcw_pkg::CFG_DW-1:0]   i_cfg_data,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output twcw_pkg::t_out_word          o_out_item
);
    import twcw_pkg::*;

    // Configuration registers.
    logic [6:0] r_win_left;
    logic [4:0] r_win_top;
    logic [6:0] r_win_width;
    logic [4:0] r_win_height;
    logic       r_scroll_en;
    logic [7:0] r_text_attr;

    // Cursor, latched word and scroll counters.
    logic [6:0]         r_cur_col;
    logic [4:0]         r_cur_row;
    t_cmd               r_cmd;
    logic [7:0]         r_ch;
    logic [6:0]         r_px;
    logic [4:0]         r_py;
    logic [6:0]         r_scr_col;
    logic [4:0]         r_scr_row;
    logic [CELL_AW-1:0] r_clr_addr;
    logic               r_src_ok;
    logic               r_scrolled;
    logic [7:0]         r_cell_char;
    logic [7:0]         r_cell_attr;

    // Cell store: character in the upper byte, attribute in the lower.
    logic [15:0] r_cells [CELL_COUNT];
    logic [15:0] r_rdata;

    // Output register.
    logic      r_out_valid;
    t_out_word r_out_item;

    logic [6:0]         w, wm1, col_s, px_sat, sel_col;
    logic [4:0]         h, hm1, row_s, py_sat, sel_row;
    logic               newline, wrap, at_bottom, wrap_scroll;
    logic [7:0]         sc;
    logic [5:0]         sr;
    logic               cell_ok;
    logic [CELL_AW-1:0] cell_addr;
    logic [CELL_AW-1:0] wr_addr;
    logic [15:0]        wr_data;
    logic               wr_en;
    logic               rd_en;

    // Effective window size: zero acts as one.
    assign w   = (r_win_width == '0) ? 7'd1 : r_win_width;
    assign h   = (r_win_height == '0) ? 5'd1 : r_win_height;
    assign wm1 = w - 7'd1;
    assign hm1 = h - 5'd1;

    // Position saturation for move and read.
    assign px_sat = (i_in_item.pos_x > {1'b0, wm1}) ? wm1 : i_in_item.pos_x[6:0];
    assign py_sat = (i_in_item.pos_y > {3'b000, hm1}) ? hm1 : i_in_item.pos_y[4:0];

    // Put-char wrap decision on a cursor clamped to the window.
    assign col_s       = (r_cur_col > w) ? w : r_cur_col;
    assign row_s       = (r_cur_row > hm1) ? hm1 : r_cur_row;
    assign newline     = (r_ch == NEWLINE_CODE);
    assign wrap        = (col_s == w) || newline;
    assign at_bottom   = (row_s == hm1);
    assign wrap_scroll = wrap && at_bottom && r_scroll_en;

    // Window cell selected for this cycle's memory access.
    always_comb begin
        sel_col = r_cur_col;
        sel_row = r_cur_row;
        case (i_ctrl.op)
            OP_READ: begin
                sel_col = r_px;
                sel_row = r_py;
            end
            OP_SCR_RD: begin
                sel_col = r_scr_col;
                sel_row = r_scr_row + 5'd1;
            end
            OP_SCR_WR: begin
                sel_col = r_scr_col;
                sel_row = r_scr_row;
            end
            OP_FILL: begin
                sel_col = r_scr_col;
                sel_row = hm1;
            end
            default: begin
                sel_col = r_cur_col;
                sel_row = r_cur_row;
            end
        endcase
    end

    // Window to screen mapping; cells off the screen are not stored.
    assign sc        = {1'b0, r_win_left} + {1'b0, sel_col};
    assign sr        = {1'b0, r_win_top} + {1'b0, sel_row};
    assign cell_ok   = (32'(sc) < SCREEN_COLS) && (32'(sr) < SCREEN_ROWS);
    assign cell_addr = CELL_AW'(sr) * CELL_AW'(SCREEN_COLS) + CELL_AW'(sc);

    // Memory write port selection.
    always_comb begin
        wr_addr = cell_addr;
        wr_data = {SPACE_CODE, DEFAULT_ATTR};
        wr_en   = 1'b0;
        case (i_ctrl.op)
            OP_CLEAR: begin
                wr_addr = r_clr_addr;
                wr_en   = 1'b1;
            end
            OP_SCR_WR: begin
                wr_data = r_src_ok ? r_rdata : 16'h0000;
                wr_en   = cell_ok;
            end
            OP_FILL: begin
                wr_data = {SPACE_CODE, r_text_attr};
                wr_en   = cell_ok;
            end
            OP_PUT: begin
                wr_data = {r_ch, r_text_attr};
                wr_en   = cell_ok;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_en = ((i_ctrl.op == OP_READ) || (i_ctrl.op == OP_SCR_RD)) && cell_ok;

    // Cell store with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cells[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_cells[cell_addr];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= 7'd0;
            r_win_top    <= 5'd0;
            r_win_width  <= 7'd80;
            r_win_height <= 5'd30;
            r_scroll_en  <= 1'b1;
            r_text_attr  <= DEFAULT_ATTR;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_WIN_LEFT:   r_win_left   <= i_cfg_data[6:0];
                REG_WIN_TOP:    r_win_top    <= i_cfg_data[4:0];
                REG_WIN_WIDTH:  r_win_width  <= i_cfg_data[6:0];
                REG_WIN_HEIGHT: r_win_height <= i_cfg_data[4:0];
                REG_SCROLL_EN:  r_scroll_en  <= i_cfg_data[0];
                REG_TEXT_ATTR:  r_text_attr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Cursor and clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col  <= 7'd0;
            r_cur_row  <= 5'd0;
            r_clr_addr <= '0;
        end else begin
            case (i_ctrl.op)
                OP_CLEAR: begin
                    r_clr_addr <= r_clr_addr + CELL_AW'(1);
                end
                OP_WRAP: begin
                    if (wrap) begin
                        r_cur_col <= 7'd0;
                        r_cur_row <= at_bottom ? row_s : row_s + 5'd1;
                    end else begin
                        r_cur_col <= col_s;
                        r_cur_row <= row_s;
                    end
                end
                OP_MOVE: begin
                    r_cur_col <= r_px;
                    r_cur_row <= r_py;
                end
                OP_PUT: begin
                    r_cur_col <= r_cur_col + 7'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // Latched word, scroll counters and result fields.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LOAD: begin
                r_cmd       <= t_cmd'(i_in_item.cmd);
                r_ch        <= i_in_item.char_code;
                r_px        <= px_sat;
                r_py        <= py_sat;
                r_scrolled  <= 1'b0;
                r_cell_char <= 8'h00;
                r_cell_attr <= 8'h00;
            end
            OP_WRAP: begin
                r_scrolled <= wrap_scroll;
                r_scr_col  <= 7'd0;
                r_scr_row  <= 5'd0;
            end
            OP_READ, OP_SCR_RD: begin
                r_src_ok <= cell_ok;
            end
            OP_CAPTURE: begin
                r_cell_char <= r_src_ok ? r_rdata[15:8] : 8'h00;
                r_cell_attr <= r_src_ok ? r_rdata[7:0] : 8'h00;
            end
            OP_SCR_WR: begin
                if (r_scr_col == wm1) begin
                    r_scr_col <= 7'd0;
                    r_scr_row <= r_scr_row + 5'd1;
                end else begin
                    r_scr_col <= r_scr_col + 7'd1;
                end
            end
            OP_FILL: begin
                r_scr_col <= (r_scr_col == wm1) ? 7'd0 : r_scr_col + 7'd1;
            end
            default: begin
            end
        endcase
    end

    // Output register: a new word loads once the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_EMIT) begin
            r_out_item.cursor_col <= r_cur_col;
            r_out_item.cursor_row <= r_cur_row;
            r_out_item.cell_char  <= r_cell_char;
            r_out_item.cell_attr  <= r_cell_attr;
            r_out_item.scrolled   <= r_scrolled;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Status back to the controller.
    assign o_status.cmd         = r_cmd;
    assign o_status.newline     = newline;
    assign o_status.wrap_scroll = wrap_scroll;
    assign o_status.single_row  = (hm1 == 5'd0);
    assign o_status.col_last    = (r_scr_col == wm1);
    assign o_status.row_last    = ((r_scr_row + 5'd1) == hm1);
    assign o_status.clear_last  = (r_clr_addr == CELL_AW'(CELL_COUNT - 1));
    assign o_status.out_free    = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// File: rtl/core/text_window_char_writer.sv
// Sequence: an accepted word is latched and decoded; a move, a newline or the unused command
// then emits its result, a read first captures the addressed cell, and a put writes its cell.
// A put or newline that scrolls first moves each window row below the top up one row and fills
// the bottom row with spaces, one cell access per cycle. Throughput: one word at a time.
// Reset: a clearing pass writes spaces with attribute 0x0F to all 2400 cells, one per cycle,
// during which no word is accepted; configuration writes are taken throughout.
`default_nettype none

module text_window_char_writer (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  twcw_pkg::t_in_word          i_in_item,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output twcw_pkg::t_out_word         o_out_item,
    input  wire                         i_cfg_we,
    input  wire [twcw_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  wire [twcw_pkg::CFG_DW-1:0]  i_cfg_data
);
    import twcw_pkg::*;

    t_dp_ctrl   ctrl;
    t_dp_status status;

    // Sequencer for the put, move, read, scroll and clearing steps.
    twcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    // Registers, cursor logic and cell store.
    twcw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
